// ===== design/i420_bgra_pkg.sv =====
// Shared constants and the channel scaling function for the I420 to BGRA converter.
`timescale 1ns / 1ps
`default_nettype none

package i420_bgra_pkg;

  // Configuration register geometry
  localparam int unsigned CFG_WIDTH   = 13;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  // Register select, taken from paddr[2]
  localparam logic REG_IMG_WIDTH  = 1'b0;
  localparam logic REG_IMG_HEIGHT = 1'b1;

  localparam logic [CFG_WIDTH-1:0] IMG_WIDTH_RST  = 13'd640;
  localparam logic [CFG_WIDTH-1:0] IMG_HEIGHT_RST = 13'd480;

  // Sum width: 298*239 + 516*127 + 128 stays well inside 20 signed bits
  localparam int unsigned SUM_W = 20;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t COEF_Y     = 20'sd298;
  localparam sum_t COEF_B_CB  = 20'sd516;
  localparam sum_t COEF_G_CB  = 20'sd100;
  localparam sum_t COEF_G_CR  = 20'sd208;
  localparam sum_t COEF_R_CR  = 20'sd409;
  localparam sum_t ROUND_HALF = 20'sd128;

  localparam logic [7:0] LUMA_OFFSET   = 8'd16;
  localparam logic [8:0] CHROMA_OFFSET = 9'd128;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

  // Drop the fraction and saturate to 0..255
  function automatic logic [7:0] scale_clamp(input sum_t v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v[SUM_W-1:16] != '0) begin
      res = 8'd255;
    end else begin
      res = v[15:8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/i420_to_bgra_pixel_converter_top.sv =====
// Top level of the I420 to BGRA pixel converter with chroma line store.
`timescale 1ns / 1ps
`default_nettype none

// Channel     Dir  Handshake               Payload
// s_axis      in   tvalid/tready           tdata[23:0] = luma, chroma_blue, chroma_red
// m_axis      out  tvalid/tready           tdata[31:0] = blue, green, red, alpha; tlast
// apb         in   psel/penable/pready     img_width @0x0, img_height @0x4
//
// One pixel per clock sustained while the output is not stalled. Stage 1 accepts
// the beat, steps the raster counters and issues the chroma line store accesses
// (a read on every beat, plus a write on even row and even column); the output
// register takes the BT.601 multiply-add, rounding and clamping.
// Reset clears the counters and the pipeline valids and loads the 640x480 size;
// the line store is not cleared. A stalled output holds both stages; the input
// still takes a beat while only the output register is full.

module i420_to_bgra_pixel_converter_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // pixel input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
  // pixel output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] blue, [15:8] green, [23:16] red, [31:24] alpha
  output logic             m_axis_tlast,   // frame_end
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [i420_bgra_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [i420_bgra_pkg::APB_DATA_W-1:0] pwdata,
  output logic [i420_bgra_pkg::APB_DATA_W-1:0]      prdata,
  output logic             pready
);

  localparam int unsigned CW        = i420_bgra_pkg::CFG_WIDTH;
  localparam int unsigned DW        = i420_bgra_pkg::APB_DATA_W;
  // size arithmetic width: holds MAX_* up to 8192 and the cleared register
  localparam int unsigned SW        = CW + 1;
  localparam int unsigned XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned LineDepth = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int unsigned AW        = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam logic [SW-1:0] MaxW    = SW'(MAX_WIDTH);
  localparam logic [SW-1:0] MaxH    = SW'(MAX_HEIGHT);
  localparam logic [SW-1:0] MinSize = SW'(2);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CW-1:0] img_width_q, img_height_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= i420_bgra_pkg::IMG_WIDTH_RST;
      img_height_q <= i420_bgra_pkg::IMG_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == i420_bgra_pkg::REG_IMG_WIDTH) begin
        img_width_q <= pwdata[CW-1:0];
      end else begin
        img_height_q <= pwdata[CW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == i420_bgra_pkg::REG_IMG_WIDTH) begin
      prdata = DW'(img_width_q);
    end else begin
      prdata = DW'(img_height_q);
    end
  end

  // Effective sizes: drop the low bit, saturate to 2..MAX
  logic [SW-1:0] width_even, height_even, eff_width, eff_height;

  assign width_even  = SW'({img_width_q[CW-1:1], 1'b0});
  assign height_even = SW'({img_height_q[CW-1:1], 1'b0});

  always_comb begin
    eff_width = width_even;
    if (eff_width < MinSize) eff_width = MinSize;
    if (eff_width > MaxW)    eff_width = MaxW;
    eff_height = height_even;
    if (eff_height < MinSize) eff_height = MinSize;
    if (eff_height > MaxH)    eff_height = MaxH;
  end

  // ---------------------------------------------------------------------------
  // Handshake: stage 1 (input register) and output register
  // ---------------------------------------------------------------------------
  logic s1_valid_q, out_valid_q;
  logic out_advance, in_accept;

  assign out_advance   = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) s1_valid_q <= s_axis_tvalid;
      if (out_advance)   out_valid_q <= s1_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Raster counters
  // ---------------------------------------------------------------------------
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic          last_col, last_row, chroma_fresh;

  assign last_col     = (SW'(col_q) + SW'(1)) >= eff_width;
  assign last_row     = (SW'(row_q) + SW'(1)) >= eff_height;
  assign chroma_fresh = !col_q[0] && !row_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + YW'(1);
      end else begin
        col_q <= col_q + XW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Chroma line store: Cb in the low byte, Cr in the high byte
  // ---------------------------------------------------------------------------
  logic [15:0]   line_mem [LineDepth];
  logic [15:0]   line_rd_q;
  logic [AW-1:0] line_addr;

  assign line_addr = AW'(col_q >> 1);

  always_ff @(posedge clk_i) begin
    if (in_accept && chroma_fresh) begin
      line_mem[line_addr] <= s_axis_tdata[23:8];
    end
    // hold the read data while the pixel waits in stage 1
    if (in_accept) begin
      line_rd_q <= line_mem[line_addr];
    end
  end

  // Stage 1 payload
  logic [7:0]  s1_luma_q;
  logic [15:0] s1_chroma_q;
  logic        s1_fresh_q, s1_last_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_luma_q   <= s_axis_tdata[7:0];
      s1_chroma_q <= s_axis_tdata[23:8];
      s1_fresh_q  <= chroma_fresh;
      s1_last_q   <= last_col && last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Color conversion
  // ---------------------------------------------------------------------------
  logic [15:0]                pair;
  logic [7:0]                 luma_c;
  logic signed [8:0]          cb_d, cr_e;
  i420_bgra_pkg::sum_t        y_term, c_term, d_term, e_term;
  i420_bgra_pkg::sum_t        blue_sum, green_sum, red_sum;

  // fresh pairs bypass the store, the read came out before the write landed
  assign pair   = s1_fresh_q ? s1_chroma_q : line_rd_q;
  assign luma_c = (s1_luma_q > i420_bgra_pkg::LUMA_OFFSET) ?
                  s1_luma_q - i420_bgra_pkg::LUMA_OFFSET : 8'd0;
  assign cb_d   = $signed({1'b0, pair[7:0]} - i420_bgra_pkg::CHROMA_OFFSET);
  assign cr_e   = $signed({1'b0, pair[15:8]} - i420_bgra_pkg::CHROMA_OFFSET);

  assign c_term = i420_bgra_pkg::sum_t'({1'b0, luma_c});
  assign d_term = i420_bgra_pkg::sum_t'(cb_d);
  assign e_term = i420_bgra_pkg::sum_t'(cr_e);
  assign y_term = i420_bgra_pkg::COEF_Y * c_term + i420_bgra_pkg::ROUND_HALF;

  assign blue_sum  = y_term + i420_bgra_pkg::COEF_B_CB * d_term;
  assign green_sum = y_term - i420_bgra_pkg::COEF_G_CB * d_term
                            - i420_bgra_pkg::COEF_G_CR * e_term;
  assign red_sum   = y_term + i420_bgra_pkg::COEF_R_CR * e_term;

  // Output register
  logic [31:0] out_data_q;
  logic        out_last_q;

  always_ff @(posedge clk_i) begin
    if (out_advance && s1_valid_q) begin
      out_data_q <= {i420_bgra_pkg::ALPHA_OPAQUE,
                     i420_bgra_pkg::scale_clamp(red_sum),
                     i420_bgra_pkg::scale_clamp(green_sum),
                     i420_bgra_pkg::scale_clamp(blue_sum)};
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the I420 to BGRA pixel converter: stream pixels, predict, compare.
`timescale 1ns / 1ps

module testbench;

  import i420_bgra_pkg::*;

  // Sizes of the block under test and of the run
  localparam int unsigned MAX_SIZE     = 4096;
  localparam int unsigned LINE_SLOTS   = MAX_SIZE / 2;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles without any beat or transfer
  localparam int unsigned TAIL_CYCLES  = 16;    // slack after the final drain
  localparam int unsigned HOLD_AFTER   = 300;   // output beats before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 400;

  // Register byte addresses, built from the package register select
  localparam logic [APB_ADDR_W-1:0] ADDR_IMG_WIDTH  = {REG_IMG_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_IMG_HEIGHT = {REG_IMG_HEIGHT, 2'b00};

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       frame_end;
  } bgra_pixel_t;

  // One directed beat; when typed is set the expected color is taken from the row
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    bit         typed;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } stim_row_t;

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN, READY_SPARSE} ready_mode_e;

  // Directed beats, sent right after reset at the reset size of 640x480, so all of
  // them land on row 0: even columns load a new chroma pair, odd columns reuse it
  // and must ignore the chroma they carry.
  localparam stim_row_t DIRECTED_ROWS [14] = '{
    '{8'd16,  8'd128, 8'd128, 1'b1, 8'd0,   8'd0,   8'd0  },  // black, neutral chroma
    '{8'd235, 8'd0,   8'd0,   1'b1, 8'd255, 8'd255, 8'd255},  // white, chroma ignored
    '{8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd154, 8'd0  },  // luma floored, low chroma
    '{8'd128, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd125, 8'd255},  // all maximum
    '{8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 8'd0,   8'd203},  // reuse of the max pair
    '{8'd16,  8'd255, 8'd0,   1'b1, 8'd255, 8'd54,  8'd0  },
    '{8'd90,  8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{8'd16,  8'd0,   8'd255, 1'b1, 8'd0,   8'd0,   8'd203},
    '{8'd200, 8'd17,  8'd99,  1'b0, 8'd0,   8'd0,   8'd0  },
    '{8'd81,  8'd90,  8'd240, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{8'd145, 8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0  },
    '{8'd17,  8'd54,  8'd34,  1'b0, 8'd0,   8'd0,   8'd0  },
    '{8'd15,  8'd200, 8'd7,   1'b0, 8'd0,   8'd0,   8'd0  }   // just below the luma floor
  };

  // Clock, reset and block inputs, all known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr  = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;

  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [31:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predicted block state
  logic [CFG_WIDTH-1:0] width_reg  = 13'd640;
  logic [CFG_WIDTH-1:0] height_reg = 13'd480;
  int unsigned          col_pos    = 0;
  int unsigned          row_pos    = 0;
  logic [15:0]          chroma_pairs [LINE_SLOTS];

  bgra_pixel_t pending_pixels [$];   // expected output beats, oldest first
  int unsigned mismatches  = 0;
  int unsigned out_beats   = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned random_sent = 0;

  // Receiver stall state
  ready_mode_e ready_mode   = READY_ALWAYS;
  int unsigned mode_left    = 0;
  int unsigned pattern_pos  = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  i420_to_bgra_pixel_converter_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] blue, [15:8] green, [23:16] red, [31:24] alpha
    .m_axis_tlast  (m_axis_tlast),   // frame_end
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Clear the low bit, then saturate to the supported range
  function automatic int effective_size(input logic [CFG_WIDTH-1:0] reg_val);
    int s;
    s = int'(reg_val & 13'h1FFE);
    if (s < 2) s = 2;
    if (s > MAX_SIZE) s = MAX_SIZE;
    return s;
  endfunction

  // Floor by 256, saturate to 0..255
  function automatic logic [7:0] scale_channel(input int v);
    if (v < 0) return 8'd0;
    if (v / 256 > 255) return 8'd255;
    return 8'(v / 256);
  endfunction

  // Convert one accepted pixel and advance the raster position
  function automatic bgra_pixel_t convert_pixel(input logic [7:0] y, cb, cr);
    int          w, h, c, d, e;
    int unsigned slot;
    bit          end_col, end_row;
    logic [15:0] pair;
    bgra_pixel_t px;
    w = effective_size(width_reg);
    h = effective_size(height_reg);
    slot = (col_pos >> 1) % LINE_SLOTS;
    end_col = (col_pos + 1 >= w);
    end_row = (row_pos + 1 >= h);
    if (col_pos[0] == 1'b0 && row_pos[0] == 1'b0) chroma_pairs[slot] = {cr, cb};
    pair = chroma_pairs[slot];
    c = int'(y) - 16;
    if (c < 0) c = 0;
    d = int'(pair[7:0]) - 128;
    e = int'(pair[15:8]) - 128;
    px.blue      = scale_channel(298 * c + 516 * d + 128);
    px.green     = scale_channel(298 * c - 100 * d - 208 * e + 128);
    px.red       = scale_channel(298 * c + 409 * e + 128);
    px.alpha     = 8'd255;
    px.frame_end = end_col && end_row;
    if (end_col) begin
      col_pos = 0;
      row_pos = end_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return px;
  endfunction

  // Count a mismatch and print one line for it
  task automatic note_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("MISMATCH @%0t %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Mostly uniform samples, with the corner values now and then
  function automatic logic [7:0] random_sample();
    logic [7:0] corners [6] = '{8'd0, 8'd255, 8'd16, 8'd15, 8'd235, 8'd128};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one pixel in bursts with random gaps; predict it once it is taken
  task automatic send_pixel(input logic [7:0] y, cb, cr, input bit typed,
                            input bgra_pixel_t typed_px);
    bgra_pixel_t px;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 250 : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cr, cb, y};
    do @(posedge clk_i); while (!s_axis_tready);
    px = convert_pixel(y, cb, cr);
    if (typed) px = typed_px;
    pending_pixels.push_back(px);
  endtask

  task automatic send_random_pixel();
    send_pixel(random_sample(), random_sample(), random_sample(), 1'b0, '0);
  endtask

  // Lower valid and let every pending pixel come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Setup cycle, access cycle, then psel is dropped before the task returns
  task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_sizes();
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b0, ADDR_IMG_WIDTH, '0, rd);
    if (rd !== 32'(width_reg)) note_mismatch("img_width readback", rd, width_reg);
    apb_access(1'b0, ADDR_IMG_HEIGHT, '0, rd);
    if (rd !== 32'(height_reg)) note_mismatch("img_height readback", rd, height_reg);
  endtask

  // Write both sizes while idle, with junk above the register width, and read them back
  task automatic write_sizes(input logic [CFG_WIDTH-1:0] w, h);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b1, ADDR_IMG_WIDTH, {19'($urandom()), w}, rd);
    width_reg = w;
    apb_access(1'b1, ADDR_IMG_HEIGHT, {19'($urandom()), h}, rd);
    height_reg = h;
    check_sizes();
  endtask

  // One phase: resize, stream count pixels, then finish on an even row so that the
  // next resize never leads to a read of a chroma slot that was never loaded
  task automatic run_phase(input logic [CFG_WIDTH-1:0] w, h, input int unsigned count);
    drain();
    write_sizes(w, h);
    repeat (count) send_random_pixel();
    while (row_pos[0]) send_random_pixel();
  endtask

  // Check each output beat against the oldest prediction
  always @(posedge clk_i) begin
    bgra_pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_beats++;
      if (pending_pixels.size() == 0) begin
        note_mismatch("output beat with nothing pending", m_axis_tdata, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[7:0] !== want.blue) note_mismatch("blue", m_axis_tdata[7:0], want.blue);
        if (m_axis_tdata[15:8] !== want.green) begin
          note_mismatch("green", m_axis_tdata[15:8], want.green);
        end
        if (m_axis_tdata[23:16] !== want.red) note_mismatch("red", m_axis_tdata[23:16], want.red);
        if (m_axis_tdata[31:24] !== want.alpha) begin
          note_mismatch("alpha", m_axis_tdata[31:24], want.alpha);
        end
        if (m_axis_tlast !== want.frame_end) begin
          note_mismatch("frame_end", m_axis_tlast, want.frame_end);
        end
      end
    end
  end

  // Receiver: switch between stall modes in random stretches, and once hold off
  // long enough for the block to fill up and push back on its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && out_beats >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = ready_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(16, 160);
        end
        mode_left--;
        pattern_pos++;
        case (ready_mode)
          READY_ALWAYS:  m_axis_tready <= 1'b1;
          READY_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
          READY_PATTERN: m_axis_tready <= (pattern_pos % 5) != 0;
          default:       m_axis_tready <= (pattern_pos % 4) == 0;
        endcase
      end
    end
  end

  // Count cycles in which nothing moves on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    bgra_pixel_t typed_px;
    logic [CFG_WIDTH-1:0] w, h;
    int unsigned before_count;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes, then the directed color beats at 640x480
    check_sizes();
    foreach (DIRECTED_ROWS[i]) begin
      typed_px = '{blue: DIRECTED_ROWS[i].blue, green: DIRECTED_ROWS[i].green,
                   red: DIRECTED_ROWS[i].red, alpha: 8'd255, frame_end: 1'b0};
      send_pixel(DIRECTED_ROWS[i].luma, DIRECTED_ROWS[i].cb, DIRECTED_ROWS[i].cr,
                 DIRECTED_ROWS[i].typed, typed_px);
    end

    // Shrink mid-row: column 14 is past the new last column, so the row ends there
    run_phase(13'd2, 13'd2, 9);
    // Sizes below the minimum saturate to 2
    run_phase(13'd0, 13'd1, 8);
    // Odd sizes lose their low bit: 6x4, two frames
    run_phase(13'd7, 13'd5, 48);
    // All register bits set: 4096 wide; leave the row partway through
    run_phase(13'h1FFF, 13'd0, 40);
    // Column 40 is past the new width, so the row ends there
    run_phase(13'd2, 13'd2, 3);
    // Tall frame, then cut it short while the row count is far beyond the new height
    run_phase(13'd2, 13'h1FFF, 20);
    run_phase(13'd12, 13'd2, 12);
    // Exactly the maximum, then a mid-frame change to a small frame
    run_phase(13'h1000, 13'h1000, 6);
    run_phase(13'd4, 13'd6, 24);

    // Random phases: mostly small frames, now and then odd or out-of-range sizes
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = 13'($urandom_range(0, 1));
        1:       w = 13'($urandom_range(17, 80));
        default: w = 13'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 9))
        0:       h = 13'($urandom_range(0, 1));
        1:       h = 13'($urandom());
        default: h = 13'($urandom_range(2, 12));
      endcase
      before_count = out_beats + pending_pixels.size();
      run_phase(w, h, $urandom_range(4, 90));
      random_sent += out_beats + pending_pixels.size() - before_count;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/i420_bgra_pkg.sv
design/i420_to_bgra_pixel_converter_top.sv
tb/testbench.sv
